### hdl/wsvp_pkg.sv
package wsvp_pkg;

  // camera-space coordinate width, Q.8
  localparam int unsigned TW = 27;

  // edge intersection dividers
  localparam int unsigned CNW = 61;
  localparam int unsigned CDW = 35;
  localparam int unsigned CQW = CNW + 1;

  // projection dividers
  localparam int unsigned PNW = 40;
  localparam int unsigned PDW = 32;
  localparam int unsigned PQW = PNW + 1;

  localparam int unsigned FOCAL      = 120;
  localparam int unsigned HEIGHT_Q8  = 768000;

  typedef enum logic [7:0] {
    REG_CAM_X = 8'd0,
    REG_CAM_Y = 8'd1,
    REG_SIN   = 8'd2,
    REG_COS   = 8'd3
  } reg_idx_e;

  typedef struct packed {
    logic                 vis0;
    logic                 detl_nz;
    logic                 detr_nz;
    logic signed [TW-1:0] tx1;
    logic signed [TW-1:0] tz1;
    logic signed [TW-1:0] tx2;
    logic signed [TW-1:0] tz2;
    logic [23:0]          tag;
  } clip_pass_t;

  typedef struct packed {
    logic        vis;
    logic [23:0] tag;
  } proj_pass_t;

  function automatic logic signed [31:0] sat_clip(input logic signed [CQW-1:0] v);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &v[CQW-1:31];
    hi_zeros = ~|v[CQW-1:31];
    if (hi_ones || hi_zeros) return v[31:0];
    else if (v[CQW-1]) return 32'sh8000_0000;
    else return 32'sh7fff_ffff;
  endfunction

  function automatic logic signed [15:0] sat_pix(input logic signed [PQW-1:0] v);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &v[PQW-1:15];
    hi_zeros = ~|v[PQW-1:15];
    if (hi_ones || hi_zeros) return v[15:0];
    else if (v[PQW-1]) return 16'sh8000;
    else return 16'sh7fff;
  endfunction

endpackage

### hdl/wsvp_div.sv
module wsvp_div #(
  parameter int unsigned NW = 40,
  parameter int unsigned DW = 32
) (
  input  logic                 clk_i,
  input  logic signed [NW-1:0] n_i,
  input  logic signed [DW-1:0] d_i,
  output logic signed [NW:0]   q_o
);

  // one quotient bit per stage, truncating signed division
  logic [DW-1:0] rem_q [0:NW];
  logic [NW-1:0] num_q [0:NW];
  logic [NW-1:0] quo_q [0:NW];
  logic [DW-1:0] dv_q  [0:NW];
  logic          neg_q [0:NW];
  logic signed [NW:0] q_q;

  always_ff @(posedge clk_i) begin
    num_q[0] <= n_i[NW-1] ? NW'(-n_i) : NW'(n_i);
    dv_q[0]  <= d_i[DW-1] ? DW'(-d_i) : DW'(d_i);
    neg_q[0] <= n_i[NW-1] ^ d_i[DW-1];
    rem_q[0] <= '0;
    quo_q[0] <= '0;
  end

  for (genvar k = 0; k < NW; k++) begin : g_step
    logic [DW:0]   trial;
    logic          take;
    logic [DW-1:0] rem_d;

    always_comb begin
      trial = {rem_q[k], num_q[k][NW-1]};
      take  = trial >= {1'b0, dv_q[k]};
      rem_d = take ? DW'(trial - {1'b0, dv_q[k]}) : trial[DW-1:0];
    end

    always_ff @(posedge clk_i) begin
      rem_q[k+1] <= rem_d;
      num_q[k+1] <= num_q[k] << 1;
      quo_q[k+1] <= {quo_q[k][NW-2:0], take};
      dv_q[k+1]  <= dv_q[k];
      neg_q[k+1] <= neg_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= neg_q[NW] ? -$signed({1'b0, quo_q[NW]}) : $signed({1'b0, quo_q[NW]});
  end

  assign q_o = q_q;

endmodule

### hdl/wall_segment_view_projector_top.sv
// wall segment view projector
// input: pulse start_i with the two wall endpoints and the colour tag; busy_o is
// always low, so a new wall may be started in every clock cycle.
// config: cfg_valid_i/cfg_ready_o with cfg_index_i (0 camera x, 1 camera y,
// 2 view sine, 3 view cosine; other indexes ignored) and cfg_data_i. write
// registers only while no wall is in flight.
// output: done_o is high for one cycle per wall, with visible_o, the two screen
// x values, the two half heights and out_tag_o; results leave in input order.
// path to done_o: five stages of camera transform, a 63 stage divider for the
// view edge intersection, the select and numerator stages, a 42 stage divider
// for the projection and one output register. throughput is one wall per cycle.
// the receiver cannot stall: each result word shows for exactly one cycle.
// reset clears every stage valid bit and loads the camera registers with
// position zero, sine zero and cosine 32767.
module wall_segment_view_projector_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [23:0] end_a_x_i,
  input  logic signed [23:0] end_a_y_i,
  input  logic signed [23:0] end_b_x_i,
  input  logic signed [23:0] end_b_y_i,
  input  logic [23:0]        wall_tag_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i,
  output logic               done_o,
  output logic               visible_o,
  output logic signed [15:0] left_screen_x_o,
  output logic signed [15:0] left_half_height_o,
  output logic signed [15:0] right_screen_x_o,
  output logic signed [15:0] right_half_height_o,
  output logic [23:0]        out_tag_o
);

  localparam int unsigned TW   = wsvp_pkg::TW;
  localparam int unsigned CNW  = wsvp_pkg::CNW;
  localparam int unsigned CDW  = wsvp_pkg::CDW;
  localparam int unsigned CQW  = wsvp_pkg::CQW;
  localparam int unsigned PNW  = wsvp_pkg::PNW;
  localparam int unsigned PDW  = wsvp_pkg::PDW;
  localparam int unsigned PQW  = wsvp_pkg::PQW;
  localparam int unsigned CLAT = CNW + 2;
  localparam int unsigned PLAT = PNW + 2;

  // camera registers
  logic signed [23:0] cam_x_q, cam_y_q;
  logic signed [15:0] sin_q, cos_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q <= '0;
      cam_y_q <= '0;
      sin_q   <= '0;
      cos_q   <= 16'sd32767;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (wsvp_pkg::reg_idx_e'(cfg_index_i))
        wsvp_pkg::REG_CAM_X: cam_x_q <= cfg_data_i;
        wsvp_pkg::REG_CAM_Y: cam_y_q <= cfg_data_i;
        wsvp_pkg::REG_SIN:   sin_q   <= cfg_data_i[15:0];
        wsvp_pkg::REG_COS:   cos_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // valid bits
  logic            s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, s5_vld_q, s6_vld_q, s7_vld_q;
  logic [CLAT-1:0] c_vld_q;
  logic [PLAT-1:0] p_vld_q;
  logic            done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      c_vld_q  <= '0;
      s6_vld_q <= 1'b0;
      s7_vld_q <= 1'b0;
      p_vld_q  <= '0;
      done_q   <= 1'b0;
    end else begin
      s1_vld_q <= start_i && !busy_o;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
      c_vld_q  <= {c_vld_q[CLAT-2:0], s5_vld_q};
      s6_vld_q <= c_vld_q[CLAT-1];
      s7_vld_q <= s6_vld_q;
      p_vld_q  <= {p_vld_q[PLAT-2:0], s7_vld_q};
      done_q   <= p_vld_q[PLAT-1];
    end
  end

  // stage 1: translate
  logic signed [24:0] s1_ax_q, s1_ay_q, s1_bx_q, s1_by_q;
  logic [23:0]        s1_tag_q;

  always_ff @(posedge clk_i) begin
    s1_ax_q  <= 25'(end_a_x_i) - 25'(cam_x_q);
    s1_ay_q  <= 25'(end_a_y_i) - 25'(cam_y_q);
    s1_bx_q  <= 25'(end_b_x_i) - 25'(cam_x_q);
    s1_by_q  <= 25'(end_b_y_i) - 25'(cam_y_q);
    s1_tag_q <= wall_tag_i;
  end

  // stage 2: rotation products
  logic signed [40:0] s2_p_q [8];
  logic [23:0]        s2_tag_q;

  always_ff @(posedge clk_i) begin
    s2_p_q[0] <= 41'(s1_ax_q) * 41'(cos_q);
    s2_p_q[1] <= 41'(s1_ay_q) * 41'(sin_q);
    s2_p_q[2] <= 41'(s1_ax_q) * 41'(sin_q);
    s2_p_q[3] <= 41'(s1_ay_q) * 41'(cos_q);
    s2_p_q[4] <= 41'(s1_bx_q) * 41'(cos_q);
    s2_p_q[5] <= 41'(s1_by_q) * 41'(sin_q);
    s2_p_q[6] <= 41'(s1_bx_q) * 41'(sin_q);
    s2_p_q[7] <= 41'(s1_by_q) * 41'(cos_q);
    s2_tag_q  <= s1_tag_q;
  end

  // stage 3: sums, floor by dropping the low 15 bits
  logic signed [41:0]   tz1_sum, tx1_sum, tz2_sum, tx2_sum;
  logic signed [TW-1:0] s3_tx1_q, s3_tz1_q, s3_tx2_q, s3_tz2_q;
  logic [23:0]          s3_tag_q;

  always_comb begin
    tz1_sum = 42'(s2_p_q[0]) + 42'(s2_p_q[1]);
    tx1_sum = 42'(s2_p_q[2]) - 42'(s2_p_q[3]);
    tz2_sum = 42'(s2_p_q[4]) + 42'(s2_p_q[5]);
    tx2_sum = 42'(s2_p_q[6]) - 42'(s2_p_q[7]);
  end

  always_ff @(posedge clk_i) begin
    s3_tz1_q <= tz1_sum[41:15];
    s3_tx1_q <= tx1_sum[41:15];
    s3_tz2_q <= tz2_sum[41:15];
    s3_tx2_q <= tx2_sum[41:15];
    s3_tag_q <= s2_tag_q;
  end

  // stage 4: cross products and deltas
  logic signed [53:0]   s4_pa_q, s4_pb_q;
  logic signed [TW:0]   s4_dx_q, s4_dz_q;
  logic signed [TW-1:0] s4_tx1_q, s4_tz1_q, s4_tx2_q, s4_tz2_q;
  logic                 s4_vis0_q;
  logic [23:0]          s4_tag_q;

  always_ff @(posedge clk_i) begin
    s4_pa_q   <= 54'(s3_tx1_q) * 54'(s3_tz2_q);
    s4_pb_q   <= 54'(s3_tz1_q) * 54'(s3_tx2_q);
    s4_dx_q   <= (TW+1)'(s3_tx1_q) - (TW+1)'(s3_tx2_q);
    s4_dz_q   <= (TW+1)'(s3_tz1_q) - (TW+1)'(s3_tz2_q);
    s4_vis0_q <= (s3_tz1_q > 0) || (s3_tz2_q > 0);
    s4_tx1_q  <= s3_tx1_q;
    s4_tz1_q  <= s3_tz1_q;
    s4_tx2_q  <= s3_tx2_q;
    s4_tz2_q  <= s3_tz2_q;
    s4_tag_q  <= s3_tag_q;
  end

  // stage 5: numerators and determinants of both view edges
  logic signed [CNW-1:0] c_w, c56_w;
  logic signed [CDW-1:0] dx_w, dz56_w;
  logic signed [CNW-1:0] s5_ncy_q, s5_nlx_q, s5_nrx_q;
  logic signed [CDW-1:0] s5_detl_q, s5_detr_q;
  wsvp_pkg::clip_pass_t  s5_pass_q;
  logic signed [CDW-1:0] detl_d, detr_d;

  always_comb begin
    c_w    = CNW'(55'(s4_pa_q) - 55'(s4_pb_q));
    c56_w  = (c_w <<< 6) - (c_w <<< 3);
    dx_w   = CDW'(s4_dx_q);
    dz56_w = (CDW'(s4_dz_q) <<< 6) - (CDW'(s4_dz_q) <<< 3);
    detl_d = -dx_w - dz56_w;
    detr_d = -dx_w + dz56_w;
  end

  always_ff @(posedge clk_i) begin
    s5_ncy_q          <= -c_w;
    s5_nlx_q          <= c56_w;
    s5_nrx_q          <= -c56_w;
    s5_detl_q         <= detl_d;
    s5_detr_q         <= detr_d;
    s5_pass_q.vis0    <= s4_vis0_q;
    s5_pass_q.detl_nz <= detl_d != '0;
    s5_pass_q.detr_nz <= detr_d != '0;
    s5_pass_q.tx1     <= s4_tx1_q;
    s5_pass_q.tz1     <= s4_tz1_q;
    s5_pass_q.tx2     <= s4_tx2_q;
    s5_pass_q.tz2     <= s4_tz2_q;
    s5_pass_q.tag     <= s4_tag_q;
  end

  // intersection dividers
  logic signed [CQW-1:0] q_ly, q_lx, q_ry, q_rx;

  wsvp_div #(.NW(CNW), .DW(CDW)) u_div_ly (
    .clk_i(clk_i), .n_i(s5_ncy_q), .d_i(s5_detl_q), .q_o(q_ly));
  wsvp_div #(.NW(CNW), .DW(CDW)) u_div_lx (
    .clk_i(clk_i), .n_i(s5_nlx_q), .d_i(s5_detl_q), .q_o(q_lx));
  wsvp_div #(.NW(CNW), .DW(CDW)) u_div_ry (
    .clk_i(clk_i), .n_i(s5_ncy_q), .d_i(s5_detr_q), .q_o(q_ry));
  wsvp_div #(.NW(CNW), .DW(CDW)) u_div_rx (
    .clk_i(clk_i), .n_i(s5_nrx_q), .d_i(s5_detr_q), .q_o(q_rx));

  wsvp_pkg::clip_pass_t c_dly_q [CLAT];

  always_ff @(posedge clk_i) begin
    c_dly_q[0] <= s5_pass_q;
    for (int i = 1; i < CLAT; i++) begin
      c_dly_q[i] <= c_dly_q[i-1];
    end
  end

  // stage 6: pick the usable edge and replace each endpoint behind the viewer
  wsvp_pkg::clip_pass_t c_out;
  logic                 left_ok, clip_ok, behind1, behind2, vis_d;
  logic signed [31:0]   clip_x, clip_z;
  logic signed [31:0]   tx1_d, tz1_d, tx2_d, tz2_d;
  logic signed [31:0]   s6_tx1_q, s6_tz1_q, s6_tx2_q, s6_tz2_q;
  logic                 s6_vis_q;
  logic [23:0]          s6_tag_q;

  always_comb begin
    c_out   = c_dly_q[CLAT-1];
    left_ok = c_out.detl_nz && !q_ly[CQW-1] && (q_ly != '0);
    if (left_ok) begin
      clip_x  = wsvp_pkg::sat_clip(q_lx);
      clip_z  = wsvp_pkg::sat_clip(q_ly);
      clip_ok = 1'b1;
    end else begin
      clip_x  = wsvp_pkg::sat_clip(q_rx);
      clip_z  = wsvp_pkg::sat_clip(q_ry);
      clip_ok = c_out.detr_nz && (clip_z > 0);
    end
    behind1 = c_out.tz1 <= 0;
    behind2 = c_out.tz2 <= 0;
    vis_d   = c_out.vis0 && (!behind1 || clip_ok) && (!behind2 || clip_ok);
    tx1_d   = behind1 ? clip_x : 32'(c_out.tx1);
    tz1_d   = behind1 ? clip_z : 32'(c_out.tz1);
    tx2_d   = behind2 ? clip_x : 32'(c_out.tx2);
    tz2_d   = behind2 ? clip_z : 32'(c_out.tz2);
  end

  always_ff @(posedge clk_i) begin
    s6_tx1_q <= tx1_d;
    s6_tz1_q <= tz1_d;
    s6_tx2_q <= tx2_d;
    s6_tz2_q <= tz2_d;
    s6_vis_q <= vis_d;
    s6_tag_q <= c_out.tag;
  end

  // stage 7: projection numerators
  logic signed [PNW-1:0] s7_n1_q, s7_n2_q;
  logic signed [PDW-1:0] s7_z1_q, s7_z2_q;
  wsvp_pkg::proj_pass_t  s7_pass_q;
  logic signed [PNW-1:0] height_w;

  assign height_w = PNW'(wsvp_pkg::HEIGHT_Q8);

  always_ff @(posedge clk_i) begin
    s7_n1_q       <= -(PNW'(s6_tx1_q) * PNW'(wsvp_pkg::FOCAL));
    s7_n2_q       <= -(PNW'(s6_tx2_q) * PNW'(wsvp_pkg::FOCAL));
    s7_z1_q       <= s6_tz1_q;
    s7_z2_q       <= s6_tz2_q;
    s7_pass_q.vis <= s6_vis_q;
    s7_pass_q.tag <= s6_tag_q;
  end

  logic signed [PQW-1:0] q_sx1, q_hh1, q_sx2, q_hh2;

  wsvp_div #(.NW(PNW), .DW(PDW)) u_div_sx1 (
    .clk_i(clk_i), .n_i(s7_n1_q), .d_i(s7_z1_q), .q_o(q_sx1));
  wsvp_div #(.NW(PNW), .DW(PDW)) u_div_hh1 (
    .clk_i(clk_i), .n_i(height_w), .d_i(s7_z1_q), .q_o(q_hh1));
  wsvp_div #(.NW(PNW), .DW(PDW)) u_div_sx2 (
    .clk_i(clk_i), .n_i(s7_n2_q), .d_i(s7_z2_q), .q_o(q_sx2));
  wsvp_div #(.NW(PNW), .DW(PDW)) u_div_hh2 (
    .clk_i(clk_i), .n_i(height_w), .d_i(s7_z2_q), .q_o(q_hh2));

  wsvp_pkg::proj_pass_t p_dly_q [PLAT];

  always_ff @(posedge clk_i) begin
    p_dly_q[0] <= s7_pass_q;
    for (int i = 1; i < PLAT; i++) begin
      p_dly_q[i] <= p_dly_q[i-1];
    end
  end

  // output word
  wsvp_pkg::proj_pass_t p_out;
  logic                 vis_q;
  logic signed [15:0]   sx1_q, hh1_q, sx2_q, hh2_q;
  logic [23:0]          tag_q;

  assign p_out = p_dly_q[PLAT-1];

  always_ff @(posedge clk_i) begin
    vis_q <= p_out.vis && p_vld_q[PLAT-1];
    sx1_q <= p_out.vis ? wsvp_pkg::sat_pix(q_sx1) : '0;
    hh1_q <= p_out.vis ? wsvp_pkg::sat_pix(q_hh1) : '0;
    sx2_q <= p_out.vis ? wsvp_pkg::sat_pix(q_sx2) : '0;
    hh2_q <= p_out.vis ? wsvp_pkg::sat_pix(q_hh2) : '0;
    tag_q <= p_out.tag;
  end

  assign done_o              = done_q;
  assign visible_o           = vis_q;
  assign left_screen_x_o     = sx1_q;
  assign left_half_height_o  = hh1_q;
  assign right_screen_x_o    = sx2_q;
  assign right_half_height_o = hh2_q;
  assign out_tag_o           = tag_q;

  // a visible wall has both depths in front after clipping
  a_clip_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s6_vld_q && s6_vis_q |-> (s6_tz1_q > 0) && (s6_tz2_q > 0))
    else $error("visible wall with depth not in front");

  // half heights of a visible wall are never negative
  a_height_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && visible_o |-> !left_half_height_o[15] && !right_half_height_o[15])
    else $error("negative half height");

  // hidden walls carry zero geometry
  a_hidden_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !visible_o |-> left_screen_x_o == '0 && left_half_height_o == '0
      && right_screen_x_o == '0 && right_half_height_o == '0)
    else $error("hidden wall with geometry");

  // visible flag only rides on a result strobe
  a_vis_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    visible_o |-> done_o)
    else $error("visible without result strobe");

endmodule

### tb/sv/wall_segment_view_projector_top_test.sv
module wall_segment_view_projector_top_test;

  localparam longint CLIP_HI = 64'sd2147483647;
  localparam longint CLIP_LO = -64'sd2147483648;

  typedef struct {
    logic        vis;
    logic [15:0] lsx;
    logic [15:0] lhh;
    logic [15:0] rsx;
    logic [15:0] rhh;
    logic [23:0] tag;
  } wall_view_t;

  class wall_view_board;
    longint cam_x, cam_y, vsin, vcos;
    wall_view_t pending[$];
    int errors, walls, shown;

    function new();
      cam_x = 0; cam_y = 0; vsin = 0; vcos = 32767;
      errors = 0; walls = 0; shown = 0;
    endfunction

    function void set_reg(wsvp_pkg::reg_idx_e idx, logic [23:0] data);
      case (idx)
        wsvp_pkg::REG_CAM_X: cam_x = longint'($signed(data));
        wsvp_pkg::REG_CAM_Y: cam_y = longint'($signed(data));
        wsvp_pkg::REG_SIN:   vsin  = longint'($signed(data[15:0]));
        wsvp_pkg::REG_COS:   vcos  = longint'($signed(data[15:0]));
        default: ;
      endcase
    endfunction

    function longint sat(longint v, longint lo, longint hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    // move an endpoint onto the left view edge, else the right one
    function bit edge_meet(longint c, longint dx, longint dz, inout longint x, inout longint z);
      longint det, q;
      det = -dx - dz * 56;
      if (det != 0) begin
        q = (-c) / det;
        if (q > 0) begin
          x = sat((c * 56) / det, CLIP_LO, CLIP_HI);
          z = sat(q, CLIP_LO, CLIP_HI);
          return 1;
        end
      end
      det = -dx + dz * 56;
      if (det == 0) return 0;
      x = sat((-c * 56) / det, CLIP_LO, CLIP_HI);
      z = sat((-c) / det, CLIP_LO, CLIP_HI);
      return z > 0;
    endfunction

    function void note(logic signed [23:0] ax_w, logic signed [23:0] ay_w,
                       logic signed [23:0] bx_w, logic signed [23:0] by_w,
                       logic [23:0] tag);
      longint ax, ay, bx, by, tz1, tz2, tx1, tx2, c, dx, dz;
      bit vis;
      wall_view_t w;
      ax = longint'(ax_w) - cam_x; ay = longint'(ay_w) - cam_y;
      bx = longint'(bx_w) - cam_x; by = longint'(by_w) - cam_y;
      tz1 = (ax * vcos + ay * vsin) >>> 15;
      tz2 = (bx * vcos + by * vsin) >>> 15;
      tx1 = (ax * vsin - ay * vcos) >>> 15;
      tx2 = (bx * vsin - by * vcos) >>> 15;
      vis = (tz1 > 0) || (tz2 > 0);
      w = '{0, 0, 0, 0, 0, tag};
      if (vis) begin
        c = tx1 * tz2 - tz1 * tx2;
        dx = tx1 - tx2;
        dz = tz1 - tz2;
        if (tz1 <= 0 && !edge_meet(c, dx, dz, tx1, tz1)) vis = 0;
        if (vis && tz2 <= 0 && !edge_meet(c, dx, dz, tx2, tz2)) vis = 0;
        if (vis && (tz1 <= 0 || tz2 <= 0)) vis = 0;
      end
      if (vis) begin
        w.lsx = 16'(sat((-tx1 * 120) / tz1, -32768, 32767));
        w.lhh = 16'(sat(768000 / tz1, -32768, 32767));
        w.rsx = 16'(sat((-tx2 * 120) / tz2, -32768, 32767));
        w.rhh = 16'(sat(768000 / tz2, -32768, 32767));
        shown++;
      end
      w.vis = vis;
      walls++;
      pending.push_back(w);
    endfunction

    function void check(wall_view_t got);
      wall_view_t e;
      if (pending.size() == 0) begin
        $error("result word with no wall outstanding, tag %h", got.tag);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.vis !== e.vis) begin
        $error("visible: expected %0d, got %0d", e.vis, got.vis); errors++;
      end
      if (got.lsx !== e.lsx) begin
        $error("left_screen_x: expected %0d, got %0d", $signed(e.lsx), $signed(got.lsx));
        errors++;
      end
      if (got.lhh !== e.lhh) begin
        $error("left_half_height: expected %0d, got %0d", $signed(e.lhh), $signed(got.lhh));
        errors++;
      end
      if (got.rsx !== e.rsx) begin
        $error("right_screen_x: expected %0d, got %0d", $signed(e.rsx), $signed(got.rsx));
        errors++;
      end
      if (got.rhh !== e.rhh) begin
        $error("right_half_height: expected %0d, got %0d", $signed(e.rhh), $signed(got.rhh));
        errors++;
      end
      if (got.tag !== e.tag) begin
        $error("out_tag: expected %h, got %h", e.tag, got.tag); errors++;
      end
    endfunction
  endclass

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               start_i = 0;
  logic               busy_o;
  logic signed [23:0] end_a_x_i = 0, end_a_y_i = 0, end_b_x_i = 0, end_b_y_i = 0;
  logic [23:0]        wall_tag_i = 0;
  logic               cfg_valid_i = 0;
  logic               cfg_ready_o;
  logic [7:0]         cfg_index_i = 0;
  logic [23:0]        cfg_data_i = 0;
  logic               done_o, visible_o;
  logic signed [15:0] left_screen_x_o, left_half_height_o, right_screen_x_o;
  logic signed [15:0] right_half_height_o;
  logic [23:0]        out_tag_o;

  wall_view_board board = new();
  bit burst_mode;

  wall_segment_view_projector_top dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o)
      board.note(end_a_x_i, end_a_y_i, end_b_x_i, end_b_y_i, wall_tag_i);
    if (rst_ni && done_o)
      board.check('{visible_o, left_screen_x_o, left_half_height_o, right_screen_x_o,
                    right_half_height_o, out_tag_o});
  end

  task automatic send_wall(logic [23:0] ax, logic [23:0] ay, logic [23:0] bx,
                           logic [23:0] by, logic [23:0] tag);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      start_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1;
    end_a_x_i <= ax; end_a_y_i <= ay; end_b_x_i <= bx; end_b_y_i <= by;
    wall_tag_i <= tag;
    do @(posedge clk_i); while (busy_o);
  endtask

  // let the pipeline empty before touching the camera registers
  task automatic drain();
    start_i <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  // the task drops the valid after each write, so it goes low between words
  task automatic write_reg(logic [7:0] idx, logic [23:0] data);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
    board.set_reg(wsvp_pkg::reg_idx_e'(idx), data);
    @(posedge clk_i);
  endtask

  task automatic set_camera(logic [23:0] cx, logic [23:0] cy, logic [15:0] s, logic [15:0] c);
    write_reg(wsvp_pkg::REG_CAM_X, cx);
    write_reg(wsvp_pkg::REG_CAM_Y, cy);
    write_reg(wsvp_pkg::REG_SIN, {8'h00, s});
    write_reg(wsvp_pkg::REG_COS, {8'h00, c});
  endtask

  // endpoint near the camera so depth, clipping and projection all get exercised
  function automatic logic [23:0] near(longint centre);
    return 24'(centre + $signed($urandom_range(0, 16384)) - 8192);
  endfunction

  task automatic random_walls(int n);
    longint cx, cy;
    int kind;
    cx = board.cam_x; cy = board.cam_y;
    repeat (n) begin
      kind = $urandom_range(0, 9);
      if ($urandom_range(0, 15) == 0) burst_mode = ~burst_mode;
      if (kind < 7)
        send_wall(near(cx), near(cy), near(cx), near(cy), 24'($urandom));
      else if (kind < 9)
        send_wall(24'(cx + $signed($urandom_range(0, 1023)) - 512), near(cy),
                  near(cx), 24'(cy + $signed($urandom_range(0, 1023)) - 512),
                  24'($urandom));
      else
        send_wall(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                  24'($urandom));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: reset camera looks down +x
    burst_mode = 0;
    send_wall(24'h000A00, 24'hFFFB00, 24'h000A00, 24'h000500, 24'h000000);
    send_wall(24'hFFF600, 24'hFFFB00, 24'hFFF600, 24'h000500, 24'hFFFFFF);
    send_wall(24'hFFF600, 24'h000100, 24'h000A00, 24'h000200, 24'h123456);
    send_wall(24'h000A00, 24'h000200, 24'hFFF600, 24'h000100, 24'h654321);
    send_wall(24'hFFF600, 24'hFFF600, 24'h000A00, 24'h000A00, 24'hABCDEF);
    send_wall(24'hFFF600, 24'h000000, 24'h000A00, 24'h000000, 24'h0F0F0F);
    send_wall(24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000001);
    send_wall(24'h000001, 24'h000000, 24'h000001, 24'h000000, 24'h800000);
    send_wall(24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    send_wall(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h555555);
    send_wall(24'h7FFFFF, 24'h000000, 24'h000100, 24'hFFFFFF, 24'hAAAAAA);
    send_wall(24'hFFFF00, 24'h000000, 24'hFFFE00, 24'h000000, 24'h010203);
    send_wall(24'h000100, 24'h000000, 24'hFFFF00, 24'h000000, 24'h040506);
    send_wall(24'h000100, 24'h007000, 24'h000100, 24'hFF9000, 24'h070809);
    burst_mode = 1;
    send_wall(24'h800000, 24'h000000, 24'h7FFFFF, 24'h000000, 24'h0A0B0C);
    send_wall(24'h001000, 24'h000000, 24'h002000, 24'h000000, 24'h0D0E0F);
    burst_mode = 0;
    random_walls(80);
    drain();

    // camera extremes and several headings, ignored indexes among the writes
    set_camera(24'h800000, 24'h7FFFFF, 16'h8000, 16'h8000);
    write_reg(8'd4, 24'h123456);
    write_reg(8'hFF, 24'hFFFFFF);
    send_wall(24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h112233);
    random_walls(70);
    drain();
    set_camera(24'h7FFFFF, 24'h800000, 16'h7FFF, 16'h7FFF);
    random_walls(70);
    drain();
    set_camera(24'h001000, 24'hFFE000, 16'h5A82, 16'h5A82);
    random_walls(80);
    drain();
    set_camera(24'h000000, 24'h000000, 16'h7FFF, 16'h0000);
    random_walls(70);
    drain();
    set_camera(24'hFF0000, 24'h002000, 16'h0000, 16'h8000);
    random_walls(70);
    drain();
    repeat (3) begin
      set_camera(24'($urandom), 24'($urandom), 16'($urandom), 16'($urandom));
      random_walls(55);
      drain();
    end

    $display("%0d walls sent through 9 camera settings, %0d of them predicted visible",
             board.walls, board.shown);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout with %0d walls outstanding", board.pending.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
